// ===== hdl/sttd_pkg.sv =====
// Shared types and constants for the sorted timestamp table
package sttd_pkg;

  // Timestamp and window width, microseconds
  localparam int STAMP_W = 52;

  // Width of the count fields on the result ports
  localparam int OUT_CNT_W = 7;

  // Window value after reset: two seconds
  localparam logic [STAMP_W-1:0] WINDOW_RESET = 52'd2000000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start_scan;  // latch the item, clear scan state
    logic scan_en;     // step the proximity / insert-point scan
    logic shift_init;  // load the shift pointer with the fill count
    logic shift_en;    // step the move of later entries
    logic write_key;   // store the key at the insert point, bump the count
    logic finish;      // register the result and strobe it
  } sttd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;   // every stored entry compared
    logic shift_done;  // every later entry moved up
    logic near;        // a stored entry lies inside the window
    logic is_add;      // current item is an add
    logic full;        // table holds CAPACITY entries
  } sttd_status_t;

endpackage

// ===== hdl/sttd_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read
module sttd_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sttd_ctrl.sv =====
// Controller: sequences scan, shift, insert and result per item
module sttd_ctrl
  import sttd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  sttd_status_t st,
  output sttd_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.start_scan = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.scan_done) begin
          if (st.is_add && !st.near && !st.full) begin
            cmd.shift_init = 1'b1;
            state_next     = ST_SHIFT;
          end else begin
            // check item, near hit or full table: state untouched
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (st.shift_done) begin
          cmd.write_key = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== hdl/sttd_dpath.sv =====
// Datapath: stamp RAM, window register, scan and shift pointers, result
module sttd_dpath
  import sttd_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sttd_cmd_t            cmd,
  output sttd_status_t         st,
  input  logic                 kind,
  input  logic [STAMP_W-1:0]   stamp,
  input  logic                 cfg_valid,
  input  logic [STAMP_W-1:0]   cfg_data,
  output logic                 done,
  output logic                 near_found,
  output logic                 inserted,
  output logic [OUT_CNT_W-1:0] slot_number,
  output logic [OUT_CNT_W-1:0] entry_total,
  output logic                 table_full
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  // Control state
  logic [CNT_W-1:0]   fill_count;
  logic [STAMP_W-1:0] near_window;
  logic [CNT_W-1:0]   scan_cnt;
  logic               cmp_valid;
  logic               near;
  logic [CNT_W-1:0]   pos;
  logic               ins;
  logic [CNT_W-1:0]   sh_dst;
  logic               wr_pending;
  logic [IDX_W-1:0]   wr_addr;

  // Item held for the whole transaction
  logic               item_kind;
  logic [STAMP_W-1:0] item_stamp;

  // RAM port signals
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [STAMP_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [STAMP_W-1:0] ram_rdata;

  // Compare and step logic
  logic               scan_rd;
  logic               sh_mv;
  logic [CNT_W-1:0]   sh_dst_m1;
  logic [STAMP_W:0]   diff;
  logic               rdata_lt;
  logic [STAMP_W-1:0] abs_diff;
  logic               is_near;
  logic               le_key;
  logic [CNT_W-1:0]   slot_val;
  logic [CNT_W+6:0]   slot_ext;
  logic [CNT_W+6:0]   fill_ext;

  sttd_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read address: shift reads entry below the destination, scan walks upward
  assign scan_rd   = cmd.scan_en && (scan_cnt != fill_count);
  assign sh_mv     = cmd.shift_en && (sh_dst != pos);
  assign sh_dst_m1 = sh_dst - ONE;
  assign ram_raddr = sh_mv ? sh_dst_m1[IDX_W-1:0] : scan_cnt[IDX_W-1:0];

  // Write port: moved entry in the cycle after its read, else the new key
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[IDX_W-1:0];
    ram_wdata = item_stamp;
    priority if (wr_pending) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.write_key) begin
      ram_we    = 1'b1;
    end
  end

  // Distance between the entry read and the key
  assign diff     = {1'b0, ram_rdata} - {1'b0, item_stamp};
  assign rdata_lt = diff[STAMP_W];
  assign abs_diff = rdata_lt ? (item_stamp - ram_rdata) : diff[STAMP_W-1:0];
  assign is_near  = (abs_diff <= near_window);
  assign le_key   = rdata_lt || (diff == '0);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      near_window <= WINDOW_RESET;
      scan_cnt    <= '0;
      cmp_valid   <= 1'b0;
      near        <= 1'b0;
      pos         <= '0;
      ins         <= 1'b0;
      sh_dst      <= '0;
      wr_pending  <= 1'b0;
      wr_addr     <= '0;
      done        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        near_window <= cfg_data;
      end
      // scan: read pipeline plus compare in the cycle after each read
      if (cmd.start_scan) begin
        scan_cnt  <= '0;
        cmp_valid <= 1'b0;
        near      <= 1'b0;
        pos       <= '0;
        ins       <= 1'b0;
      end else if (cmd.scan_en) begin
        if (scan_rd) begin
          scan_cnt <= scan_cnt + ONE;
        end
        cmp_valid <= scan_rd;
        if (cmp_valid) begin
          if (is_near) begin
            near <= 1'b1;
          end
          // sorted table: entries not above the key form a prefix
          if (le_key) begin
            pos <= pos + ONE;
          end
        end
      end
      // shift: move entries from the top down to the insert point
      if (cmd.shift_init) begin
        sh_dst     <= fill_count;
        wr_pending <= 1'b0;
      end else if (cmd.shift_en) begin
        if (sh_mv) begin
          sh_dst  <= sh_dst_m1;
          wr_addr <= sh_dst[IDX_W-1:0];
        end
        wr_pending <= sh_mv;
      end
      if (cmd.write_key) begin
        fill_count <= fill_count + ONE;
        ins        <= 1'b1;
      end
      done <= cmd.finish;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      item_kind  <= kind;
      item_stamp <= stamp;
    end
  end

  // Result fields, cut to the port width
  assign slot_val = pos + ONE;
  assign slot_ext = {7'b0, slot_val};
  assign fill_ext = {7'b0, fill_count};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      near_found  <= near;
      inserted    <= ins;
      slot_number <= ins ? slot_ext[OUT_CNT_W-1:0] : '0;
      entry_total <= fill_ext[OUT_CNT_W-1:0];
      table_full  <= item_kind && !near && !ins;
    end
  end

  // Status
  assign st.scan_done  = (scan_cnt == fill_count) && !cmp_valid;
  assign st.shift_done = (sh_dst == pos) && !wr_pending;
  assign st.near       = near;
  assign st.is_add     = item_kind;
  assign st.full       = (fill_count == CAP_CNT);

endmodule

// ===== hdl/sorted_timestamp_table_dedup_core.sv =====
// Sorted timestamp table with near-duplicate rejection. An item is taken
// when start is high and busy is low; busy stays high until the item is
// finished, and its result then appears on the result ports for exactly one
// cycle with done high. The receiver cannot stall: sample the result in the
// cycle done is high. The scan reads the N stored entries, one RAM read per
// cycle, and compares each entry in the cycle after its read; a check item,
// or an add that finds a near entry or a full table, then finishes. An add
// that inserts at 0-based position P then moves the N - P later entries up
// through the single RAM write port, writes the key and then registers the
// result. A new item may be started in the cycle done is high. The window
// register is written over the cfg channel, which is always ready; write it
// only while the block is idle.
module sorted_timestamp_table_dedup_core
  import sttd_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [STAMP_W-1:0]   stamp,
  output logic                 done,
  output logic                 near_found,
  output logic                 inserted,
  output logic [OUT_CNT_W-1:0] slot_number,
  output logic [OUT_CNT_W-1:0] entry_total,
  output logic                 table_full,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [STAMP_W-1:0]   cfg_data
);

  sttd_cmd_t    cmd;
  sttd_status_t st;

  // Sequencer
  sttd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Storage, compare and result
  sttd_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .kind        (kind),
    .stamp       (stamp),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .done        (done),
    .near_found  (near_found),
    .inserted    (inserted),
    .slot_number (slot_number),
    .entry_total (entry_total),
    .table_full  (table_full)
  );

  // Window register takes a write in any cycle
  assign cfg_ready = 1'b1;

endmodule

// ===== hdl/sttd_checker.sv =====
// Port-level checks for the sorted timestamp table
module sttd_checker
  import sttd_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic                 near_found,
  input logic                 inserted,
  input logic [OUT_CNT_W-1:0] slot_number,
  input logic [OUT_CNT_W-1:0] entry_total,
  input logic                 table_full
);

  // Counts fit the result fields without wrapping
  localparam bit NARROW = (CAPACITY < 128);

  // An accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  // A result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // An insert excludes both the near hit and the full flag, slot within table
  a_insert_fields: assert property (@(posedge clk) disable iff (rst)
    (done && inserted && NARROW) |->
      (!near_found && !table_full && (slot_number != '0) &&
       (slot_number <= entry_total)))
    else $error("inconsistent fields on insert");

  // A refused add reports no slot and no near hit
  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (!inserted && !near_found && (slot_number == '0)))
    else $error("inconsistent fields on full table");

  // Entry total never exceeds the table size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (done && NARROW) |-> (int'(entry_total) <= CAPACITY))
    else $error("entry total above capacity");

endmodule

bind sorted_timestamp_table_dedup_core sttd_checker #(
  .CAPACITY (CAPACITY)
) u_sttd_checker (.*);
